// File: rtl/cawf_pkg.sv
package cawf_pkg;

  typedef enum logic [4:0] {
    OP_ADD       = 5'd0,
    OP_ADC       = 5'd1,
    OP_SUB       = 5'd2,
    OP_SBC       = 5'd3,
    OP_AND       = 5'd4,
    OP_OR        = 5'd5,
    OP_XOR       = 5'd6,
    OP_CP        = 5'd7,
    OP_INC       = 5'd8,
    OP_DEC       = 5'd9,
    OP_SWAP      = 5'd10,
    OP_BIT       = 5'd11,
    OP_RES       = 5'd12,
    OP_SET       = 5'd13,
    OP_RLC       = 5'd14,
    OP_RRC       = 5'd15,
    OP_RL        = 5'd16,
    OP_RR        = 5'd17,
    OP_SLA       = 5'd18,
    OP_SRA       = 5'd19,
    OP_SRL       = 5'd20,
    OP_DAA       = 5'd21,
    OP_ADD16     = 5'd22,
    OP_SP_OFFSET = 5'd23,
    OP_INC16     = 5'd24,
    OP_DEC16     = 5'd25
  } cawf_op_e;

  // flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // decimal adjust constants
  localparam logic [8:0] DaaLowFix  = 9'h006;
  localparam logic [8:0] DaaHighFix = 9'h060;
  localparam logic [8:0] DaaLimit   = 9'h09F;
  localparam logic [3:0] DaaDigit   = 4'd9;

  typedef struct packed {
    cawf_op_e           op;
    logic [7:0]         left8;
    logic [7:0]         right8;
    logic [2:0]         bit_index;
    logic [15:0]        left16;
    logic [15:0]        right16;
    logic signed [7:0]  offset;
    logic [3:0]         flags;
  } cawf_req_t;

  typedef struct packed {
    logic [7:0]  result8;
    logic [15:0] result16;
    logic [3:0]  flags;
  } cawf_rsp_t;

endpackage

// File: rtl/cawf_alu.sv
module cawf_alu (
  input  cawf_pkg::cawf_req_t req_i,
  output cawf_pkg::cawf_rsp_t rsp_o
);
  import cawf_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic [3:0]  f;
  logic        cin;
  logic        ci_add;
  logic        ci_sub;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  bit_mask;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [15:0] off_ext;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;
  logic [8:0]  daa_add;
  logic [8:0]  daa_t;
  logic [7:0]  daa_sub;
  logic [7:0]  sh_r;
  logic        sh_c;

  assign a   = req_i.left8;
  assign b   = req_i.right8;
  assign f   = req_i.flags;
  assign cin = f[FlagC];

  // byte add / subtract with carry-in, widened to 9 bits for the carry out
  assign ci_add = (req_i.op == OP_ADC) & cin;
  assign ci_sub = (req_i.op == OP_SBC) & cin;
  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, ci_add};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci_add};
  assign diff9  = {1'b0, a} - {1'b0, b} - {8'd0, ci_sub};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci_sub};

  assign bit_mask = 8'd1 << req_i.bit_index;

  // word arithmetic
  assign sum17   = {1'b0, req_i.left16} + {1'b0, req_i.right16};
  assign hsum13  = {1'b0, req_i.left16[11:0]} + {1'b0, req_i.right16[11:0]};
  assign off_ext = {{8{req_i.offset[7]}}, req_i.offset};
  assign sp_h5   = {1'b0, req_i.left16[3:0]} + {1'b0, req_i.offset[3:0]};
  assign sp_c9   = {1'b0, req_i.left16[7:0]} + {1'b0, req_i.offset};

  // decimal adjust, add mode then subtract mode
  assign daa_add = ((f[FlagH]) || (a[3:0] > DaaDigit)) ? ({1'b0, a} + DaaLowFix)
                                                       : {1'b0, a};
  assign daa_t   = (cin || (daa_add > DaaLimit)) ? (daa_add + DaaHighFix) : daa_add;
  always_comb begin
    daa_sub = a;
    if (f[FlagH]) daa_sub = daa_sub - DaaLowFix[7:0];
    if (cin)      daa_sub = daa_sub - DaaHighFix[7:0];
  end

  // rotates and shifts
  always_comb begin
    sh_r = 8'd0;
    sh_c = 1'b0;
    case (req_i.op)
      OP_RLC: begin sh_r = {a[6:0], a[7]}; sh_c = a[7]; end
      OP_RL:  begin sh_r = {a[6:0], cin};  sh_c = a[7]; end
      OP_SLA: begin sh_r = {a[6:0], 1'b0}; sh_c = a[7]; end
      OP_RRC: begin sh_r = {a[0], a[7:1]}; sh_c = a[0]; end
      OP_RR:  begin sh_r = {cin, a[7:1]};  sh_c = a[0]; end
      OP_SRA: begin sh_r = {a[7], a[7:1]}; sh_c = a[0]; end
      OP_SRL: begin sh_r = {1'b0, a[7:1]}; sh_c = a[0]; end
      default: begin sh_r = 8'd0; sh_c = 1'b0; end
    endcase
  end

  always_comb begin
    rsp_o.result8  = 8'd0;
    rsp_o.result16 = 16'd0;
    rsp_o.flags    = f;
    case (req_i.op)
      OP_ADD, OP_ADC: begin
        rsp_o.result8 = sum9[7:0];
        rsp_o.flags   = {(sum9[7:0] == 8'd0), 1'b0, hsum5[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        rsp_o.result8 = (req_i.op == OP_CP) ? a : diff9[7:0];
        rsp_o.flags   = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
      end
      OP_AND: begin
        rsp_o.result8 = a & b;
        rsp_o.flags   = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_OR: begin
        rsp_o.result8 = a | b;
        rsp_o.flags   = {((a | b) == 8'd0), 3'b000};
      end
      OP_XOR: begin
        rsp_o.result8 = a ^ b;
        rsp_o.flags   = {((a ^ b) == 8'd0), 3'b000};
      end
      OP_INC: begin
        rsp_o.result8 = a + 8'd1;
        rsp_o.flags   = {(a == 8'hFF), 1'b0, (a[3:0] == 4'hF), cin};
      end
      OP_DEC: begin
        rsp_o.result8 = a - 8'd1;
        rsp_o.flags   = {(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cin};
      end
      OP_SWAP: begin
        rsp_o.result8 = {a[3:0], a[7:4]};
        rsp_o.flags   = {(a == 8'd0), 3'b000};
      end
      OP_BIT: begin
        rsp_o.result8 = a;
        rsp_o.flags   = {~a[req_i.bit_index], 1'b0, 1'b1, cin};
      end
      OP_RES: rsp_o.result8 = a & ~bit_mask;
      OP_SET: rsp_o.result8 = a | bit_mask;
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        rsp_o.result8 = sh_r;
        rsp_o.flags   = {(sh_r == 8'd0), 2'b00, sh_c};
      end
      OP_DAA: begin
        if (!f[FlagN]) begin
          rsp_o.result8 = daa_t[7:0];
          rsp_o.flags   = {(daa_t[7:0] == 8'd0), 1'b0, 1'b0,
                           (cin || (daa_add > DaaLimit))};
        end else begin
          rsp_o.result8 = daa_sub;
          rsp_o.flags   = {(daa_sub == 8'd0), 1'b1, 1'b0, cin};
        end
      end
      OP_ADD16: begin
        rsp_o.result16 = sum17[15:0];
        rsp_o.flags    = {f[FlagZ], 1'b0, hsum13[12], sum17[16]};
      end
      OP_SP_OFFSET: begin
        rsp_o.result16 = req_i.left16 + off_ext;
        rsp_o.flags    = {2'b00, sp_h5[4], sp_c9[8]};
      end
      OP_INC16: rsp_o.result16 = req_i.left16 + 16'd1;
      OP_DEC16: rsp_o.result16 = req_i.left16 - 16'd1;
      default: begin
        rsp_o.result8  = 8'd0;
        rsp_o.result16 = 16'd0;
        rsp_o.flags    = f;
      end
    endcase
  end

endmodule

// File: rtl/cpu_alu_with_flags_top.sv
// channel | direction | handshake              | payload
// --------+-----------+------------------------+------------------------------------------
// in      | in        | in_valid_i/in_ready_o   | op, left8, right8, bit_index, left16,
//         |           |                        | right16, offset, flags_in
// out     | out       | out_valid_o/out_ready_i | result8, result16, flags_out
//
// an accepted word passes through the input register, the alu and the result register;
// a stall on out_ready_i can hold it in either register before the result handshake
// one word per cycle sustained while out_ready_i stays high; the only work is the single alu pass between the registers
// rst_ni clears both valid bits asynchronously, payload registers are not reset
// a stall on out_ready_i backs up one stage at a time; in_ready_o drops only when both
// the input and result registers are full and the result is not being taken
module cpu_alu_with_flags_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [4:0]        op_i,
  input  logic [7:0]        left8_i,
  input  logic [7:0]        right8_i,
  input  logic [2:0]        bit_index_i,
  input  logic [15:0]       left16_i,
  input  logic [15:0]       right16_i,
  input  logic signed [7:0] offset_i,
  input  logic [3:0]        flags_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        result8_o,
  output logic [15:0]       result16_o,
  output logic [3:0]        flags_out_o
);
  import cawf_pkg::*;

  // stage control
  logic      in_valid_q, in_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  logic      in_accept;

  // payload
  cawf_req_t req_q, req_d;
  cawf_rsp_t rsp_q, rsp_d;
  cawf_rsp_t alu_rsp;

  // result register frees up when empty or being drained
  assign out_free   = !out_valid_q || out_ready_i;
  // input register takes a word when empty or when it hands its word onward
  assign in_ready_o = !in_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    req_d.op        = cawf_op_e'(op_i);
    req_d.left8     = left8_i;
    req_d.right8    = right8_i;
    req_d.bit_index = bit_index_i;
    req_d.left16    = left16_i;
    req_d.right16   = right16_i;
    req_d.offset    = offset_i;
    req_d.flags     = flags_in_i;
  end

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (out_free) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    out_valid_d = out_free ? in_valid_q : out_valid_q;
    rsp_d       = alu_rsp;
  end

  // single pass alu between the two registers
  cawf_alu u_alu (
    .req_i (req_q),
    .rsp_o (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_d;
    end
    if (out_free && in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result8_o   = rsp_q.result8;
  assign result16_o  = rsp_q.result16;
  assign flags_out_o = rsp_q.flags;

  // a word waiting in the input register moves to a free result register
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> out_valid_q)
    else $error("word in input register did not advance");

  // both registers full with a stalled output must block input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipeline full");

  // bit set and clear leave the flags untouched
  a_res_set_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && (req_q.op == OP_RES || req_q.op == OP_SET) |-> alu_rsp.flags == req_q.flags)
    else $error("res/set changed flags");

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cawf_pkg::*;

  // hard stop, far beyond the slowest legal run
  localparam int unsigned CycleLimit = 200000;
  // receiver hold-off long enough to back up both pipeline stages
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned BurstWords = 16;
  localparam int unsigned PhaseWords = 100;
  localparam int unsigned NumPhases = 4;
  // leave some slack after the last word
  localparam int unsigned TailCycles = 8;

  // keeps a golden copy of the alu and the queue of results still owed
  class alu_flags_model;
    cawf_rsp_t   owed_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // work out what one accepted operation must produce and queue it
    function void log_operation(cawf_req_t w);
      logic [7:0]  a, b, r8;
      logic [15:0] r16;
      logic [3:0]  f, fo;
      logic        ci, shout;
      logic [4:0]  nib;
      logic [8:0]  s9;
      logic [9:0]  adj;
      logic [12:0] s13;
      logic [16:0] s17;
      cawf_rsp_t   rsp;
      a   = w.left8;
      b   = w.right8;
      f   = w.flags;
      r8  = '0;
      r16 = '0;
      fo  = f;
      case (w.op)
        OP_ADD, OP_ADC: begin
          // carry-in joins at full width so it reaches H and C
          ci  = (w.op == OP_ADC) & f[FlagC];
          s9  = {1'b0, a} + {1'b0, b} + {8'd0, ci};
          nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
          r8  = s9[7:0];
          fo  = '0;
          fo[FlagZ] = (r8 == 8'd0);
          fo[FlagH] = nib[4];
          fo[FlagC] = s9[8];
        end
        OP_SUB, OP_SBC, OP_CP: begin
          // borrow shows up as the sign bit of the widened difference
          ci  = (w.op == OP_SBC) & f[FlagC];
          s9  = {1'b0, a} - {1'b0, b} - {8'd0, ci};
          nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
          r8  = (w.op == OP_CP) ? a : s9[7:0];
          fo  = '0;
          fo[FlagZ] = (s9[7:0] == 8'd0);
          fo[FlagN] = 1'b1;
          fo[FlagH] = nib[4];
          fo[FlagC] = s9[8];
        end
        OP_AND: begin
          r8 = a & b;
          fo = '0;
          fo[FlagZ] = (r8 == 8'd0);
          fo[FlagH] = 1'b1;
        end
        OP_OR, OP_XOR, OP_SWAP: begin
          case (w.op)
            OP_OR:   r8 = a | b;
            OP_XOR:  r8 = a ^ b;
            default: r8 = {a[3:0], a[7:4]};
          endcase
          fo = '0;
          fo[FlagZ] = (r8 == 8'd0);
        end
        OP_INC, OP_DEC: begin
          r8 = (w.op == OP_INC) ? a + 8'd1 : a - 8'd1;
          fo = '0;
          fo[FlagZ] = (r8 == 8'd0);
          fo[FlagN] = (w.op == OP_DEC);
          fo[FlagH] = (w.op == OP_INC) ? (a[3:0] == 4'hF) : (a[3:0] == 4'h0);
          fo[FlagC] = f[FlagC];
        end
        OP_BIT: begin
          r8 = a;
          fo = '0;
          fo[FlagZ] = ~a[w.bit_index];
          fo[FlagH] = 1'b1;
          fo[FlagC] = f[FlagC];
        end
        OP_RES, OP_SET: begin
          r8 = a;
          r8[w.bit_index] = (w.op == OP_SET);
        end
        OP_RLC, OP_RL, OP_SLA: begin
          shout = a[7];
          case (w.op)
            OP_RLC:  ci = a[7];
            OP_RL:   ci = f[FlagC];
            default: ci = 1'b0;
          endcase
          r8 = {a[6:0], ci};
          fo = '0;
          fo[FlagZ] = (r8 == 8'd0);
          fo[FlagC] = shout;
        end
        OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
          shout = a[0];
          case (w.op)
            OP_RRC:  ci = a[0];
            OP_RR:   ci = f[FlagC];
            OP_SRA:  ci = a[7];
            default: ci = 1'b0;
          endcase
          r8 = {ci, a[7:1]};
          fo = '0;
          fo[FlagZ] = (r8 == 8'd0);
          fo[FlagC] = shout;
        end
        OP_DAA: begin
          adj = {2'b00, a};
          ci  = f[FlagC];
          if (!f[FlagN]) begin
            if (f[FlagH] || (a[3:0] > DaaDigit)) adj = adj + DaaLowFix;
            if (ci || (adj > DaaLimit)) begin
              adj = adj + DaaHighFix;
              ci  = 1'b1;
            end
          end else begin
            if (f[FlagH]) adj = (adj - DaaLowFix) & 10'h0FF;
            if (ci) adj = (adj - DaaHighFix) & 10'h0FF;
          end
          r8 = adj[7:0];
          fo = '0;
          fo[FlagZ] = (r8 == 8'd0);
          fo[FlagN] = f[FlagN];
          fo[FlagC] = ci;
        end
        OP_ADD16: begin
          s17 = {1'b0, w.left16} + {1'b0, w.right16};
          s13 = {1'b0, w.left16[11:0]} + {1'b0, w.right16[11:0]};
          r16 = s17[15:0];
          fo  = '0;
          fo[FlagZ] = f[FlagZ];
          fo[FlagH] = s13[12];
          fo[FlagC] = s17[16];
        end
        OP_SP_OFFSET: begin
          // sign-extended add, flags from the low byte treated unsigned
          r16 = w.left16 + {{8{w.offset[7]}}, w.offset[7:0]};
          nib = {1'b0, w.left16[3:0]} + {1'b0, w.offset[3:0]};
          s9  = {1'b0, w.left16[7:0]} + {1'b0, w.offset[7:0]};
          fo  = '0;
          fo[FlagH] = nib[4];
          fo[FlagC] = s9[8];
        end
        OP_INC16: r16 = w.left16 + 16'd1;
        OP_DEC16: r16 = w.left16 - 16'd1;
        default: ;
      endcase
      rsp.result8  = r8;
      rsp.result16 = r16;
      rsp.flags    = fo;
      owed_results.push_back(rsp);
    endfunction

    // match one delivered result against the oldest owed one
    function void compare_result(cawf_rsp_t got);
      cawf_rsp_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result r8=%02h r16=%04h flags=%01h",
                 $time, got.result8, got.result16, got.flags);
        return;
      end
      want = owed_results.pop_front();
      if (got.result8 !== want.result8) begin
        mismatches++;
        $display("%0t: result8 mismatch, expected %02h, got %02h",
                 $time, want.result8, got.result8);
      end
      if (got.result16 !== want.result16) begin
        mismatches++;
        $display("%0t: result16 mismatch, expected %04h, got %04h",
                 $time, want.result16, got.result16);
      end
      if (got.flags !== want.flags) begin
        mismatches++;
        $display("%0t: flags mismatch, expected %04b, got %04b",
                 $time, want.flags, got.flags);
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [4:0]        op_i        = '0;
  logic [7:0]        left8_i     = '0;
  logic [7:0]        right8_i    = '0;
  logic [2:0]        bit_index_i = '0;
  logic [15:0]       left16_i    = '0;
  logic [15:0]       right16_i   = '0;
  logic signed [7:0] offset_i    = '0;
  logic [3:0]        flags_in_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        result8_o;
  logic [15:0]       result16_o;
  logic [3:0]        flags_out_o;

  alu_flags_model model;

  // shared between the sender and the receiver; set by the sender, read at falling
  // edges by the receiver, which also clears hold_off_req
  bit steady_flow = 1'b0;
  bit hold_off_req = 1'b0;

  int unsigned cycle_count = 0;

  cpu_alu_with_flags_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .left8_i     (left8_i),
    .right8_i    (right8_i),
    .bit_index_i (bit_index_i),
    .left16_i    (left16_i),
    .right16_i   (right16_i),
    .offset_i    (offset_i),
    .flags_in_i  (flags_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result8_o   (result8_o),
    .result16_o  (result16_o),
    .flags_out_o (flags_out_o)
  );

  always #5 clk_i = ~clk_i;

  // operand values lean toward the corners where flags flip
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h0F;
      3:       return 8'hF0;
      4:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0FFF;
      3:       return {8'($urandom), 8'hFF};
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic cawf_req_t random_word();
    cawf_req_t w;
    w.op        = cawf_op_e'($urandom_range(0, OP_DEC16));
    w.left8     = pick_byte();
    w.right8    = pick_byte();
    w.bit_index = 3'($urandom_range(0, 7));
    w.left16    = pick_word16();
    w.right16   = pick_word16();
    w.offset    = pick_byte();
    w.flags     = 4'($urandom_range(0, 15));
    return w;
  endfunction

  // present one word at the falling edge and hold it until the alu takes it
  task automatic drive_word(input cawf_req_t w);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    op_i        <= w.op;
    left8_i     <= w.left8;
    right8_i    <= w.right8;
    bit_index_i <= w.bit_index;
    left16_i    <= w.left16;
    right16_i   <= w.right16;
    offset_i    <= w.offset;
    flags_in_i  <= w.flags;
    do @(posedge clk_i); while (!in_ready_o);
    model.log_operation(w);
  endtask

  // drop valid for a number of cycles; next drive_word raises it again
  task automatic idle_input(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // withdraw the input, then wait for every owed result
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (model.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // result side: check everything the alu hands over
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      model.compare_result('{result8: result8_o, result16: result16_o,
                             flags: flags_out_o});
    end
  end

  // result side back-pressure; the long hold-off is counted here
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldOffCycles;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        stall_left  = pick_gap();
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("cpu_alu_with_flags_top verification failed");
    $finish;
  end

  initial begin
    cawf_req_t w;
    model = new();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pass: every operation once, operands chosen for its corner case
    steady_flow = 1'b1;
    for (int k = 0; k <= OP_DEC16; k++) begin
      w    = random_word();
      w.op = cawf_op_e'(k);
      case (w.op)
        OP_ADD:       begin w.left8 = 8'hFF; w.right8 = 8'h01; w.flags = 4'h0; end
        // carry-in alone pushes both nibble and byte over
        OP_ADC:       begin w.left8 = 8'h0F; w.right8 = 8'hF0; w.flags = 4'h1; end
        OP_SUB:       begin w.left8 = 8'h00; w.right8 = 8'h01; end
        // borrow-in makes the low nibble underflow
        OP_SBC:       begin w.left8 = 8'h10; w.right8 = 8'h0F; w.flags = 4'h1; end
        OP_AND:       begin w.left8 = 8'hF0; w.right8 = 8'h0F; end
        OP_OR:        begin w.left8 = 8'h00; w.right8 = 8'h00; end
        OP_XOR:       begin w.left8 = 8'hFF; w.right8 = 8'hFF; end
        OP_CP:        begin w.left8 = 8'h42; w.right8 = 8'h42; end
        // wrap to zero, carry must survive untouched
        OP_INC:       begin w.left8 = 8'hFF; w.flags = 4'h1; end
        OP_DEC:       begin w.left8 = 8'h10; w.flags = 4'h0; end
        OP_SWAP:      w.left8 = 8'hA5;
        OP_BIT:       begin w.left8 = 8'h7F; w.bit_index = 3'd7; w.flags = 4'h1; end
        OP_RES:       begin w.left8 = 8'hFF; w.bit_index = 3'd0; w.flags = 4'hF; end
        OP_SET:       begin w.left8 = 8'h00; w.bit_index = 3'd7; w.flags = 4'h0; end
        OP_RLC:       w.left8 = 8'h80;
        OP_RRC:       w.left8 = 8'h01;
        // rotate through carry with H and N set on the way in
        OP_RL:        begin w.left8 = 8'h80; w.flags = 4'h6; end
        OP_RR:        begin w.left8 = 8'h00; w.flags = 4'h7; end
        OP_SLA:       w.left8 = 8'hFF;
        OP_SRA:       w.left8 = 8'h81;
        OP_SRL:       w.left8 = 8'h01;
        // both corrections in add mode
        OP_DAA:       begin w.left8 = 8'h9A; w.flags = 4'h0; end
        // half carry out of bit 11 and full carry together
        OP_ADD16:     begin w.left16 = 16'h0FFF; w.right16 = 16'hF001; end
        // negative offset, flags from the low byte
        OP_SP_OFFSET: begin w.left16 = 16'h00FF; w.offset = -8'sd1; end
        OP_INC16:     begin w.left16 = 16'hFFFF; w.flags = 4'hF; end
        OP_DEC16:     begin w.left16 = 16'h0000; w.flags = 4'h0; end
        default: ;
      endcase
      drive_word(w);
    end

    // random phases; the first runs back to back on both sides
    for (int phase = 0; phase < NumPhases; phase++) begin
      steady_flow = (phase == 0);
      if (phase == 2) begin
        // sender pause until the alu is empty, then jam it against a stalled receiver
        drain_results();
        steady_flow  = 1'b1;
        hold_off_req = 1'b1;
        repeat (BurstWords) drive_word(random_word());
        steady_flow  = 1'b0;
      end
      for (int n = 0; n < PhaseWords; n++) begin
        if (!steady_flow) idle_input(pick_gap());
        drive_word(random_word());
      end
    end

    idle_input(1);
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (model.mismatches == 0 && model.owed_results.size() == 0) begin
      $display("cpu_alu_with_flags_top verification clean");
    end else begin
      $display("cpu_alu_with_flags_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cawf_pkg.sv
rtl/cawf_alu.sv
rtl/cpu_alu_with_flags_top.sv
verif/tb.sv
